/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define LTSW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");

// Concurrent check that also holds during reset.
`define LTSW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m: check failed");

`endif

/* hw/rtl/ltsw_pkg.sv */
// Types and constants of the stop-and-wait sender.
`default_nettype none

package ltsw_pkg;

  // Scale of the loss ratio: losses are compared as a percentage.
  localparam int unsigned PctScale = 100;

  // Register index of the tolerated loss percentage.
  localparam logic [0:0] REG_LOSS_TOL = 1'b0;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_IGNORED   = 3'd0,
    ACT_TRANSMIT  = 3'd1,
    ACT_DELIVERED = 3'd2,
    ACT_LOSS_OK   = 3'd3,
    ACT_REJECTED  = 3'd4
  } action_e;

  typedef struct packed {
    action_e    action;
    logic       seq_bit;
    logic [3:0] loss_count;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/ltsw_arq.sv */
// Link state and per-event decision logic of the stop-and-wait sender.
`default_nettype none

module ltsw_arq #(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [1:0]      op_i,
  input  wire logic            ack_flag_i,
  input  wire logic            syn_flag_i,
  input  wire logic            ack_bit_i,
  input  wire logic [6:0]      tol_i,
  output ltsw_pkg::result_t    res_o
);

  localparam int unsigned PosW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned ProdW = $clog2(128 * WINDOW + 1);
  localparam int unsigned LcW   = (CntW > 4) ? CntW : 4;

  logic [WINDOW-1:0] win_q, win_d;
  logic [PosW-1:0]   pos_q, pos_d, pos_nxt;
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_ok, cnt_loss;
  logic              seq_q, seq_d;
  logic              busy_q, busy_d;
  logic              slot;
  logic              tolerated;
  logic [ProdW-1:0]  loss_scaled, tol_limit;
  logic [LcW-1:0]    cnt_ext;
  ltsw_pkg::action_e act;

  assign slot     = win_q[pos_q];
  assign cnt_ok   = slot ? cnt_q : cnt_q - 1'b1;
  assign cnt_loss = slot ? cnt_q + 1'b1 : cnt_q;
  assign pos_nxt  = (pos_q == PosW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;

  // floor(100*L/W) <= tol  <=>  100*L < (tol+1)*W
  assign loss_scaled = ProdW'(cnt_loss) * ProdW'(ltsw_pkg::PctScale);
  assign tol_limit   = (ProdW'(tol_i) + 1'b1) * ProdW'(WINDOW);
  assign tolerated   = loss_scaled < tol_limit;

  always_comb begin
    win_d  = win_q;
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    seq_d  = seq_q;
    busy_d = busy_q;
    act    = ltsw_pkg::ACT_IGNORED;
    unique case (ltsw_pkg::op_e'(op_i))
      ltsw_pkg::OP_SEND: begin
        if (busy_q) begin
          act = ltsw_pkg::ACT_REJECTED;
        end else begin
          busy_d = 1'b1;
          act    = ltsw_pkg::ACT_TRANSMIT;
        end
      end
      ltsw_pkg::OP_ACK: begin
        if (busy_q && ack_flag_i && !syn_flag_i && (ack_bit_i != seq_q)) begin
          win_d[pos_q] = 1'b1;
          cnt_d        = cnt_ok;
          pos_d        = pos_nxt;
          seq_d        = ~seq_q;
          busy_d       = 1'b0;
          act          = ltsw_pkg::ACT_DELIVERED;
        end
      end
      ltsw_pkg::OP_TIMEOUT: begin
        if (busy_q) begin
          win_d[pos_q] = 1'b0;
          cnt_d        = cnt_loss;
          if (tolerated) begin
            pos_d  = pos_nxt;
            busy_d = 1'b0;
            act    = ltsw_pkg::ACT_LOSS_OK;
          end else begin
            act = ltsw_pkg::ACT_TRANSMIT;
          end
        end
      end
      ltsw_pkg::OP_RSVD: begin
        act = ltsw_pkg::ACT_IGNORED;
      end
      default: begin
        act = ltsw_pkg::ACT_IGNORED;
      end
    endcase
  end

  assign cnt_ext           = LcW'(cnt_d);
  assign res_o.action      = act;
  assign res_o.seq_bit     = seq_q;
  assign res_o.loss_count  = cnt_ext[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '1;
      pos_q  <= '0;
      cnt_q  <= '0;
      seq_q  <= 1'b0;
      busy_q <= 1'b0;
    end else if (fire_i) begin
      win_q  <= win_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      seq_q  <= seq_d;
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/loss_tolerant_stop_wait_sender.sv */
// Top level of the loss-tolerant stop-and-wait sender.
//
//  channel  | direction | handshake             | word
//  ---------+-----------+-----------------------+------------------------------------
//  in       | input     | in_valid_i/in_ready_o | op, ack_flag, syn_flag, ack_bit
//  out      | output    | out_valid_o/out_ready_i | action, seq_bit, loss_count
//  cfg      | input     | APB, pready tied high | loss_tolerance_pct at 0x0
//
// The decision is taken in the cycle a word is accepted and lands in the result
// register, so a word may follow in every cycle while the output does not stall.
// in_ready_o is high whenever the result register is empty or being drained.
// Reset (asynchronous, active low) leaves the window all successes, sequence
// bit zero, link idle and tolerance zero; no clearing pass is needed.
// A stalled output holds its word and blocks new input only while it stalls.
`default_nettype none

module loss_tolerant_stop_wait_sender #(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // event words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic        ack_flag_i,
  input  wire logic        syn_flag_i,
  input  wire logic        ack_bit_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       action_o,
  output logic             seq_bit_o,
  output logic [3:0]       loss_count_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic              fire;
  logic              reg_sel;
  logic [6:0]        tol_q;
  logic              out_valid_q, out_valid_d;
  ltsw_pkg::result_t res;
  ltsw_pkg::result_t res_q;

  // Register index is the word address; byte-offset bits are don't-care.
  assign reg_sel = (paddr[2] == ltsw_pkg::REG_LOSS_TOL);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {25'd0, tol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      tol_q <= pwdata[6:0];
    end
  end

  // Accept whenever the result register is free now or freed this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  ltsw_arq #(
    .WINDOW (WINDOW)
  ) u_arq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .op_i       (op_i),
    .ack_flag_i (ack_flag_i),
    .syn_flag_i (syn_flag_i),
    .ack_bit_i  (ack_bit_i),
    .tol_i      (tol_q),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: no reset needed, qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = res_q.action;
  assign seq_bit_o    = res_q.seq_bit;
  assign loss_count_o = res_q.loss_count;

endmodule

`default_nettype wire

/* hw/rtl/ltsw_chk.sv */
// Port-level checker for the stop-and-wait sender, with its bind.
`default_nettype none
`include "assert_macros.svh"

module ltsw_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  op_i,
  input wire logic        ack_flag_i,
  input wire logic        syn_flag_i,
  input wire logic        ack_bit_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  action_o,
  input wire logic        seq_bit_o,
  input wire logic [3:0]  loss_count_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // Configuration port never inserts wait states.
  `LTSW_ASSERT_ALWAYS(a_pready_high, clk_i, pready)

  // An empty result register must never hold off the input side.
  `LTSW_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // Only defined action codes are ever presented.
  `LTSW_ASSERT(a_action_code, clk_i, rst_ni, out_valid_o |-> (action_o <= 3'd4))

  // A stalled result stays valid.
  `LTSW_ASSERT(a_out_hold_valid, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // A stalled result keeps its word.
  `LTSW_ASSERT(a_out_hold_word, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> $stable({action_o, seq_bit_o, loss_count_o}))

endmodule

bind loss_tolerant_stop_wait_sender ltsw_chk u_ltsw_chk (.*);

`default_nettype wire

/* tb/tb_loss_tolerant_stop_wait_sender.sv */
// Self-checking bench for the loss-tolerant stop-and-wait sender: table plus random event words.
module tb_loss_tolerant_stop_wait_sender;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotCount  = 10;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 150;

  // Directed table: event words, or a tolerance write between them.
  typedef enum bit {ROW_EVENT, ROW_CONFIG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    ltsw_pkg::op_e     op;
    logic              ackf;
    logic              synf;
    logic              abit;
    bit                typed;  // expected word written in by hand
    ltsw_pkg::result_t want;
    logic [6:0]        tol;
  } stim_row_t;

  localparam int NumRows = 27;

  // Hand-written expectations hold for the sequence from reset, tolerance zero.
  stim_row_t directed_rows [NumRows] = '{
    // ack, timeout and reserved op while idle: all ignored
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 1, 0, 1, 1, '{ltsw_pkg::ACT_IGNORED, 1'b0, 4'd0}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_TIMEOUT, 0, 0, 0, 1, '{ltsw_pkg::ACT_IGNORED, 1'b0, 4'd0}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_RSVD, 1, 1, 1, 1, '{ltsw_pkg::ACT_IGNORED, 1'b0, 4'd0}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_SEND, 0, 0, 0, 1, '{ltsw_pkg::ACT_TRANSMIT, 1'b0, 4'd0}, 7'd0},
    // send while waiting is turned away
    '{ROW_EVENT, ltsw_pkg::OP_SEND, 1, 1, 1, 1, '{ltsw_pkg::ACT_REJECTED, 1'b0, 4'd0}, 7'd0},
    // acks that do not match: stale bit, flag clear, syn set
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 1, 0, 0, 1, '{ltsw_pkg::ACT_IGNORED, 1'b0, 4'd0}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 0, 0, 1, 1, '{ltsw_pkg::ACT_IGNORED, 1'b0, 4'd0}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 1, 1, 1, 1, '{ltsw_pkg::ACT_IGNORED, 1'b0, 4'd0}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_RSVD, 0, 0, 0, 0, '0, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 1, 0, 1, 1, '{ltsw_pkg::ACT_DELIVERED, 1'b0, 4'd0}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_SEND, 0, 0, 0, 1, '{ltsw_pkg::ACT_TRANSMIT, 1'b1, 4'd0}, 7'd0},
    // zero tolerance: loss forces a retransmit; second loss on the same slot
    // leaves the count alone
    '{ROW_EVENT, ltsw_pkg::OP_TIMEOUT, 0, 0, 0, 1, '{ltsw_pkg::ACT_TRANSMIT, 1'b1, 4'd1}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_TIMEOUT, 1, 1, 1, 1, '{ltsw_pkg::ACT_TRANSMIT, 1'b1, 4'd1}, 7'd0},
    // delivery overwrites the lost slot
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 1, 0, 0, 1, '{ltsw_pkg::ACT_DELIVERED, 1'b1, 4'd0}, 7'd0},
    '{ROW_CONFIG, ltsw_pkg::OP_SEND, 0, 0, 0, 0, '0, 7'd100},
    '{ROW_EVENT, ltsw_pkg::OP_SEND, 0, 0, 0, 1, '{ltsw_pkg::ACT_TRANSMIT, 1'b0, 4'd0}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_TIMEOUT, 0, 0, 0, 1, '{ltsw_pkg::ACT_LOSS_OK, 1'b0, 4'd1}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_SEND, 0, 0, 0, 1, '{ltsw_pkg::ACT_TRANSMIT, 1'b0, 4'd1}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 1, 0, 0, 1, '{ltsw_pkg::ACT_IGNORED, 1'b0, 4'd1}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 1, 0, 1, 1, '{ltsw_pkg::ACT_DELIVERED, 1'b0, 4'd1}, 7'd0},
    // tolerance above a hundred: every loss given up
    '{ROW_CONFIG, ltsw_pkg::OP_SEND, 0, 0, 0, 0, '0, 7'd127},
    '{ROW_EVENT, ltsw_pkg::OP_SEND, 0, 0, 0, 1, '{ltsw_pkg::ACT_TRANSMIT, 1'b1, 4'd1}, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_TIMEOUT, 0, 0, 0, 1, '{ltsw_pkg::ACT_LOSS_OK, 1'b1, 4'd2}, 7'd0},
    '{ROW_CONFIG, ltsw_pkg::OP_SEND, 0, 0, 0, 0, '0, 7'd10},
    '{ROW_EVENT, ltsw_pkg::OP_SEND, 1, 0, 1, 0, '0, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_TIMEOUT, 0, 1, 0, 0, '0, 7'd0},
    '{ROW_EVENT, ltsw_pkg::OP_ACK, 1, 0, 0, 0, '0, 7'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = ltsw_pkg::OP_SEND;
  logic        ack_flag_i = 1'b0;
  logic        syn_flag_i = 1'b0;
  logic        ack_bit_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  action_o;
  logic        seq_bit_o;
  logic [3:0]  loss_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Travels with the payload so the monitor knows a hand-typed expectation.
  bit                row_typed = 1'b0;
  ltsw_pkg::result_t row_want = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned sent_words = 0;

  // Predictor's copy of the sender state.
  bit          slot_ok [SlotCount];
  int unsigned slot_pos;
  int unsigned loss_tally;
  logic        cur_seq;
  bit          waiting;
  logic [6:0]  tol_pct;

  ltsw_pkg::result_t pending_results [$];

  loss_tolerant_stop_wait_sender #(.WINDOW(SlotCount)) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .op_i, .ack_flag_i, .syn_flag_i, .ack_bit_i,
    .out_valid_o, .out_ready_i, .action_o, .seq_bit_o, .loss_count_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Marks the current slot, keeping the running loss tally in step.
  function automatic void record_outcome(bit ok);
    if (slot_ok[slot_pos] && !ok) begin
      loss_tally++;
    end else if (!slot_ok[slot_pos] && ok) begin
      loss_tally--;
    end
    slot_ok[slot_pos] = ok;
  endfunction

  function automatic ltsw_pkg::result_t predict_sender_event(ltsw_pkg::op_e op, logic ackf,
                                                             logic synf, logic abit);
    ltsw_pkg::result_t r;
    r.action  = ltsw_pkg::ACT_IGNORED;
    r.seq_bit = cur_seq;
    case (op)
      ltsw_pkg::OP_SEND: begin
        if (waiting) begin
          r.action = ltsw_pkg::ACT_REJECTED;
        end else begin
          waiting  = 1'b1;
          r.action = ltsw_pkg::ACT_TRANSMIT;
        end
      end
      ltsw_pkg::OP_ACK: begin
        if (waiting && ackf && !synf && abit != cur_seq) begin
          record_outcome(1'b1);
          slot_pos = (slot_pos + 1) % SlotCount;
          cur_seq  = ~cur_seq;
          waiting  = 1'b0;
          r.action = ltsw_pkg::ACT_DELIVERED;
        end
      end
      ltsw_pkg::OP_TIMEOUT: begin
        if (waiting) begin
          record_outcome(1'b0);
          // floor of the loss percentage against the tolerance
          if ((ltsw_pkg::PctScale * loss_tally) / SlotCount <= tol_pct) begin
            slot_pos = (slot_pos + 1) % SlotCount;
            waiting  = 1'b0;
            r.action = ltsw_pkg::ACT_LOSS_OK;
          end else begin
            r.action = ltsw_pkg::ACT_TRANSMIT;
          end
        end
      end
      default: ;
    endcase
    r.loss_count = loss_tally[3:0];
    return r;
  endfunction

  // Monitor: outputs and handshakes sampled at the edge, before any update lands.
  // The check runs ahead of the push, so a word accepted on this edge is never
  // matched against itself.
  always @(posedge clk_i) begin : watch
    ltsw_pkg::result_t want;
    ltsw_pkg::result_t predicted;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: action %0d", action_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (action_o !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, action_o);
            errors++;
          end
          if (seq_bit_o !== want.seq_bit) begin
            $error("seq_bit: expected %0d, got %0d", want.seq_bit, seq_bit_o);
            errors++;
          end
          if (loss_count_o !== want.loss_count) begin
            $error("loss_count: expected %0d, got %0d", want.loss_count, loss_count_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted = predict_sender_event(ltsw_pkg::op_e'(op_i), ack_flag_i, syn_flag_i,
                                         ack_bit_i);
        pending_results.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here once asked for.
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("loss_tolerant_stop_wait_sender: mismatch");
      $finish;
    end
  end

  // Offers one event word and returns on the edge that accepts it. Valid stays
  // high on return, so back-to-back words keep it up without a dip.
  task automatic send_event(ltsw_pkg::op_e op, logic ackf, logic synf, logic abit, bit typed,
                            ltsw_pkg::result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    ack_flag_i <= ackf;
    syn_flag_i <= synf;
    ack_bit_i  <= abit;
    row_typed  <= typed;
    row_want   <= want;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    sent_words++;
  endtask

  // Drops valid and waits for every expected word. The first edge lets the
  // monitor take in the last accepted word before the queue is looked at.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  // APB write: setup, then access; the register takes the value on the access edge.
  task automatic write_loss_tolerance(logic [6:0] pct);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ltsw_pkg::REG_LOSS_TOL, 2'b00};
    pwdata  <= {25'd0, pct};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tol_pct = pct;
  endtask

  // Mostly well-formed exchanges (send, a few timeouts, one or two acks) with
  // random headers, plus stray words of any kind. Runs until about goal words
  // have been accepted.
  task automatic random_traffic(int unsigned goal);
    int unsigned start;
    int unsigned n;
    start = sent_words;
    while (sent_words - start < goal) begin
      if ($urandom_range(0, 99) < 80) begin
        send_event(ltsw_pkg::OP_SEND, 1'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        n = $urandom_range(0, 4);
        repeat (n) begin
          send_event(ltsw_pkg::OP_TIMEOUT, 1'($urandom), 1'($urandom), 1'($urandom), 1'b0,
                     '0);
        end
        n = $urandom_range(1, 2);
        repeat (n) begin
          send_event(ltsw_pkg::OP_ACK, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
                     1'($urandom), 1'b0, '0);
        end
      end else begin
        send_event(ltsw_pkg::op_e'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                   1'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SlotCount; i++) begin
      slot_ok[i] = 1'b1;
    end
    slot_pos   = 0;
    loss_tally = 0;
    cur_seq    = 1'b0;
    waiting    = 1'b0;
    tol_pct    = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, gap-free on the sender side, light stalls on the receiver.
    recv_idle_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain_results();
        write_loss_tolerance(directed_rows[i].tol);
      end else begin
        send_event(directed_rows[i].op, directed_rows[i].ackf, directed_rows[i].synf,
                   directed_rows[i].abit, directed_rows[i].typed, directed_rows[i].want);
      end
    end
    drain_results();

    // Three idling regimes, each through four tolerance settings:
    // none, full, above range, and a random one.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 64 : 0;
      recv_idle_pct = (mode == 0) ? 64 : (mode == 1) ? 38 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        write_loss_tolerance((seg == 0) ? 7'd0 : (seg == 1) ? 7'd100 :
                             (seg == 2) ? 7'd127 : 7'($urandom_range(0, 127)));
        // long receiver hold-off while words keep coming: fills the result
        // register and stalls the input side
        if (mode == 2 && seg == 0) begin
          hold_go <= 1'b1;
        end
        random_traffic(68);
        drain_results();
      end
    end

    if (errors == 0) begin
      $display("loss_tolerant_stop_wait_sender: match");
    end else begin
      $display("loss_tolerant_stop_wait_sender: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ltsw_pkg.sv
hw/rtl/ltsw_arq.sv
hw/rtl/loss_tolerant_stop_wait_sender.sv
hw/rtl/ltsw_chk.sv
tb/tb_loss_tolerant_stop_wait_sender.sv
